// ===== hdl/ucpt_pkg.sv =====
// Shared types, constants and helpers for the unicycle point-tracking controller.
// No dependencies; imported by every module of the block.
package ucpt_pkg;

	localparam int GAIN_W      = 24;
	localparam int IN_W        = 32;
	localparam int HEAD_W      = 19;
	localparam int SPEED_W     = 14;
	localparam int TURN_W      = 19;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int ATAN_LEN    = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KX      = 2'd0,
		REG_KY      = 2'd1,
		REG_HEADING = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// atan(2^-i), Q2.30, truncated
	localparam longint ATAN_Q30 [ATAN_LEN] = '{
		64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
		64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
		64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
		64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
		64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
		64'sd1023,      64'sd511,       64'sd255,       64'sd127
	};
	localparam longint PI_Q30 = 64'sd3373259426;

	// Q2.30 to frac fraction bits, round half up
	function automatic longint from_q30(input longint a, input int frac);
		int sh;
		sh = 30 - frac;
		return (a + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// width of the velocity demands ux, uy
	function automatic int ux_width(input int frac);
		return max_int(IN_W, GAIN_W + IN_W + 2 - frac) + 1;
	endfunction

endpackage

// ===== hdl/ucpt_front.sv =====
// Front end: takes ticks, drops disabled ones, forms the velocity demands ux, uy.
// Depends on ucpt_pkg; feeds ucpt_queue.
module ucpt_front import ucpt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [GAIN_W-1:0]             kx_gain,
	input  logic [GAIN_W-1:0]             ky_gain,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          enabled,
	input  logic signed [IN_W-1:0]        pos_x,
	input  logic signed [IN_W-1:0]        pos_y,
	input  logic signed [HEAD_W-1:0]      heading,
	input  logic signed [IN_W-1:0]        target_x,
	input  logic signed [IN_W-1:0]        target_vx,
	input  logic signed [IN_W-1:0]        target_y,
	input  logic signed [IN_W-1:0]        target_vy,
	input  queue_stat_t                   stat,
	output logic                          push,
	output logic [2*ux_width(FRAC_BITS)+HEAD_W-1:0] entry
);

	localparam int UW = ux_width(FRAC_BITS);
	localparam int DW = IN_W + 1;
	localparam int PW = GAIN_W + IN_W + 2;

	logic adv;
	logic v_s1_q, v_s2_q, v_s3_q;
	logic signed [DW-1:0]     dx_s1, dy_s1;
	logic signed [IN_W-1:0]   tvx_s1, tvy_s1, tvx_s2, tvy_s2;
	logic signed [HEAD_W-1:0] th_s1, th_s2, th_s3;
	logic signed [PW-1:0]     px_s2, py_s2;
	logic signed [UW-1:0]     ux_s3, uy_s3;

	assign adv      = !v_s3_q || !stat.full;
	assign in_ready = adv;
	assign push     = v_s3_q && !stat.full;
	assign entry    = {th_s3, uy_s3, ux_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else if (adv) begin
			v_s1_q <= in_valid && enabled;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= DW'(pos_x) - DW'(target_x);
			dy_s1  <= DW'(pos_y) - DW'(target_y);
			tvx_s1 <= target_vx;
			tvy_s1 <= target_vy;
			th_s1  <= heading;
			px_s2  <= PW'($signed({1'b0, kx_gain})) * PW'(dx_s1);
			py_s2  <= PW'($signed({1'b0, ky_gain})) * PW'(dy_s1);
			tvx_s2 <= tvx_s1;
			tvy_s2 <= tvy_s1;
			th_s2  <= th_s1;
			// floor shift of the product
			ux_s3  <= UW'(tvx_s2) - UW'(px_s2 >>> FRAC_BITS);
			uy_s3  <= UW'(tvy_s2) - UW'(py_s2 >>> FRAC_BITS);
			th_s3  <= th_s2;
		end
	end

endmodule

// ===== hdl/ucpt_queue.sv =====
// Short queue between the front end and the back end.
// Depends on ucpt_pkg for depth and status struct.
module ucpt_queue import ucpt_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output queue_stat_t   stat
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [DW-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == CW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue full and empty at once");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		AW'(wr_ptr_q - rd_ptr_q) == AW'(count_q))
		else $error("queue pointers disagree with count");

endmodule

// ===== hdl/ucpt_back.sv =====
// Back end: speed by pipelined square root, heading by pipelined CORDIC,
// heading wrap and turn-rate gain. Depends on ucpt_pkg; reads ucpt_queue.
module ucpt_back import ucpt_pkg::*; #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [GAIN_W-1:0]          heading_gain,
	input  logic [2*ux_width(FRAC_BITS)+HEAD_W-1:0] entry,
	input  queue_stat_t                stat,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SPEED_W-1:0]         speed_cmd,
	output logic signed [TURN_W-1:0]   turn_rate_cmd
);

	localparam int     UW   = ux_width(FRAC_BITS);
	localparam int     NW   = max_int(UW, 42);
	localparam int     CW   = NW + 3;
	localparam int     ZW   = FRAC_BITS + 5;
	localparam int     EW   = max_int(ZW, HEAD_W) + 2;
	localparam int     HW   = GAIN_W + 1 + EW;
	localparam int     OW   = HW + 1;
	localparam longint SMAX = ((longint'(22) << FRAC_BITS) + 50) / 100;
	localparam longint WMAX = ((longint'(284) << FRAC_BITS) + 50) / 100;
	localparam int     AW   = $clog2(SMAX + 1);
	localparam int     SB   = AW + 1;
	localparam int     RW   = 2 * SB;
	localparam int     NC   = min_int(CORDIC_STAGES, ATAN_LEN);
	localparam int     L    = max_int(NC, SB);
	localparam longint PI_F = from_q30(PI_Q30, FRAC_BITS);

	localparam logic [UW-1:0]        SMAX_U  = UW'(SMAX);
	localparam logic [RW-1:0]        SMAX_R  = RW'(SMAX);
	localparam logic [AW-1:0]        SMAX_A  = AW'(SMAX);
	localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_F);
	localparam logic signed [EW-1:0] TWO_PI  = EW'(2 * PI_F);
	localparam logic signed [OW-1:0] WMAX_P  = OW'(WMAX);
	localparam logic signed [OW-1:0] WMAX_N  = -OW'(WMAX);

	typedef struct packed {
		logic signed [CW-1:0]     x;
		logic signed [CW-1:0]     y;
		logic signed [ZW-1:0]     z;
		logic signed [ZW-1:0]     base;
		logic                     zero;
		logic                     sat;
		logic [RW-1:0]            n;
		logic [RW-1:0]            r;
		logic signed [HEAD_W-1:0] th;
	} lane_t;

	function automatic logic fits(input logic [NW-1:0] m, input int k);
		return (m >> (41 - k)) == '0;
	endfunction

	logic be;
	logic signed [UW-1:0]     ux, uy;
	logic signed [HEAD_W-1:0] th;
	logic [UW-1:0]            abs_ux, abs_uy;
	logic signed [CW-1:0]     x0, y0, abs_y0;

	// stage 1: fold, saturation check
	logic v_s1, zero_s1, sat_s1;
	logic signed [CW-1:0]     x_s1, y_s1;
	logic [NW-1:0]            m_s1;
	logic signed [ZW-1:0]     base_s1;
	logic [AW-1:0]            ax_s1, ay_s1;
	logic signed [HEAD_W-1:0] th_s1;
	// stage 2: squares, coarse normalize
	logic v_s2, zero_s2, sat_s2;
	logic signed [CW-1:0]     x_s2, y_s2;
	logic [NW-1:0]            m_s2;
	logic signed [ZW-1:0]     base_s2;
	logic [2*AW-1:0]          sqx_s2, sqy_s2;
	logic signed [HEAD_W-1:0] th_s2;
	// stage 3: radicand, mid normalize
	logic v_s3, zero_s3, sat_s3;
	logic signed [CW-1:0]     x_s3, y_s3;
	logic [NW-1:0]            m_s3;
	logic signed [ZW-1:0]     base_s3;
	logic [RW-1:0]            n_s3;
	logic signed [HEAD_W-1:0] th_s3;
	// lanes
	lane_t lane_s [L+1];
	logic  lv_s   [L+1];
	// tail
	logic v_s5, v_s6, v_s7;
	logic signed [ZW-1:0]     td_s5;
	logic [AW-1:0]            spd_s5, spd_s6, spd_s7;
	logic signed [HEAD_W-1:0] th_s5;
	logic signed [EW-1:0]     err_s6;
	logic signed [HW-1:0]     prod_s7;

	logic [NW-1:0]        m_a, m_b, m_c;
	logic signed [CW-1:0] x_a, y_a, x_b, y_b, x_c, y_c;
	logic [RW-1:0]        r_fin;
	logic signed [ZW-1:0] td_c;
	logic [AW-1:0]        spd_c;
	logic signed [EW-1:0] thv, tdv, d0, dp, dm, e0, ep, em, err_c;
	logic signed [OW-1:0] om;

	logic                     out_valid_q;
	logic [SPEED_W-1:0]       speed_q;
	logic signed [TURN_W-1:0] turn_q;

	assign be            = !out_valid_q || out_ready;
	assign pop           = be && !stat.empty;
	assign out_valid     = out_valid_q;
	assign speed_cmd     = speed_q;
	assign turn_rate_cmd = turn_q;

	always_comb begin
		ux     = $signed(entry[UW-1:0]);
		uy     = $signed(entry[2*UW-1:UW]);
		th     = $signed(entry[2*UW+HEAD_W-1:2*UW]);
		abs_ux = ux[UW-1] ? UW'(-ux) : UW'(ux);
		abs_uy = uy[UW-1] ? UW'(-uy) : UW'(uy);
		x0     = ux[UW-1] ? -CW'(ux) : CW'(ux);
		y0     = ux[UW-1] ? -CW'(uy) : CW'(uy);
		abs_y0 = y0[CW-1] ? -y0 : y0;
	end

	// normalize so the larger of |x|, |y| lands in [2^40, 2^41); values from 2^41 up are left unshifted
	always_comb begin
		m_a = m_s1; x_a = x_s1; y_a = y_s1;
		if (fits(m_a, 32)) begin m_a = m_a << 32; x_a = x_a <<< 32; y_a = y_a <<< 32; end
		if (fits(m_a, 16)) begin m_a = m_a << 16; x_a = x_a <<< 16; y_a = y_a <<< 16; end
		m_b = m_s2; x_b = x_s2; y_b = y_s2;
		if (fits(m_b, 8)) begin m_b = m_b << 8; x_b = x_b <<< 8; y_b = y_b <<< 8; end
		if (fits(m_b, 4)) begin m_b = m_b << 4; x_b = x_b <<< 4; y_b = y_b <<< 4; end
		m_c = m_s3; x_c = x_s3; y_c = y_s3;
		if (fits(m_c, 2)) begin m_c = m_c << 2; x_c = x_c <<< 2; y_c = y_c <<< 2; end
		if (fits(m_c, 1)) begin m_c = m_c << 1; x_c = x_c <<< 1; y_c = y_c <<< 1; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			lv_s[0]     <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (be) begin
			v_s1        <= !stat.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			lv_s[0]     <= v_s3;
			v_s5        <= lv_s[L];
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			x_s1    <= x0;
			y_s1    <= y0;
			m_s1    <= (x0 > abs_y0) ? NW'(x0) : NW'(abs_y0);
			base_s1 <= !ux[UW-1] ? '0 : (uy[UW-1] ? -PI_Z : PI_Z);
			zero_s1 <= (ux == '0) && (uy == '0);
			sat_s1  <= (abs_ux > SMAX_U) || (abs_uy > SMAX_U);
			ax_s1   <= abs_ux[AW-1:0];
			ay_s1   <= abs_uy[AW-1:0];
			th_s1   <= th;

			x_s2    <= x_a;
			y_s2    <= y_a;
			m_s2    <= m_a;
			base_s2 <= base_s1;
			zero_s2 <= zero_s1;
			sat_s2  <= sat_s1;
			sqx_s2  <= (2*AW)'(ax_s1) * (2*AW)'(ax_s1);
			sqy_s2  <= (2*AW)'(ay_s1) * (2*AW)'(ay_s1);
			th_s2   <= th_s1;

			x_s3    <= x_b;
			y_s3    <= y_b;
			m_s3    <= m_b;
			base_s3 <= base_s2;
			zero_s3 <= zero_s2;
			sat_s3  <= sat_s2;
			n_s3    <= RW'(sqx_s2) + RW'(sqy_s2);
			th_s3   <= th_s2;

			lane_s[0].x    <= x_c;
			lane_s[0].y    <= y_c;
			lane_s[0].z    <= '0;
			lane_s[0].base <= base_s3;
			lane_s[0].zero <= zero_s3;
			lane_s[0].sat  <= sat_s3;
			lane_s[0].n    <= n_s3;
			lane_s[0].r    <= '0;
			lane_s[0].th   <= th_s3;
		end
	end

	// one CORDIC micro-rotation per lane below NC and one square-root digit per lane below SB
	for (genvar l = 0; l < L; l++) begin : g_lane
		localparam logic signed [ZW-1:0] AT =
			ZW'(from_q30(ATAN_Q30[(l < ATAN_LEN) ? l : 0], FRAC_BITS));
		localparam int SH = (l < SB) ? 2 * (SB - 1 - l) : 0;
		localparam logic [RW-1:0] BIT = RW'(1) << SH;
		lane_t         nxt;
		logic [RW-1:0] rb;

		always_comb begin
			nxt = lane_s[l];
			rb  = lane_s[l].r + BIT;
			if (l < NC) begin
				if (!lane_s[l].y[CW-1]) begin
					nxt.x = lane_s[l].x + (lane_s[l].y >>> l);
					nxt.y = lane_s[l].y - (lane_s[l].x >>> l);
					nxt.z = lane_s[l].z + AT;
				end else begin
					nxt.x = lane_s[l].x - (lane_s[l].y >>> l);
					nxt.y = lane_s[l].y + (lane_s[l].x >>> l);
					nxt.z = lane_s[l].z - AT;
				end
			end
			if (l < SB) begin
				if (lane_s[l].n >= rb) begin
					nxt.n = lane_s[l].n - rb;
					nxt.r = (lane_s[l].r >> 1) + BIT;
				end else begin
					nxt.r = lane_s[l].r >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lv_s[l+1] <= 1'b0;
			else if (be) lv_s[l+1] <= lv_s[l];
		end

		always_ff @(posedge clk) begin
			if (be) lane_s[l+1] <= nxt;
		end
	end

	always_comb begin
		r_fin = lane_s[L].r;
		td_c  = lane_s[L].zero ? '0 : lane_s[L].base + lane_s[L].z;
		if (lane_s[L].sat || r_fin > SMAX_R) spd_c = SMAX_A;
		else                                 spd_c = r_fin[AW-1:0];

		// pick the copy of the desired heading nearest the measured one
		thv = EW'(th_s5);
		tdv = EW'(td_s5);
		d0  = thv - tdv;
		dp  = d0 - TWO_PI;
		dm  = d0 + TWO_PI;
		e0  = d0[EW-1] ? -d0 : d0;
		ep  = dp[EW-1] ? -dp : dp;
		em  = dm[EW-1] ? -dm : dm;
		if (e0 > ep)      err_c = dp;
		else if (e0 > em) err_c = dm;
		else              err_c = d0;

		om = (-OW'(prod_s7)) >>> FRAC_BITS;
		if (om > WMAX_P)      om = WMAX_P;
		else if (om < WMAX_N) om = WMAX_N;
	end

	always_ff @(posedge clk) begin
		if (be) begin
			td_s5   <= td_c;
			spd_s5  <= spd_c;
			th_s5   <= lane_s[L].th;
			err_s6  <= err_c;
			spd_s6  <= spd_s5;
			prod_s7 <= HW'($signed({1'b0, heading_gain})) * HW'(err_s6);
			spd_s7  <= spd_s6;
			speed_q <= SPEED_W'(spd_s7);
			turn_q  <= TURN_W'(om);
		end
	end

endmodule

// ===== hdl/unicycle_point_tracking_control.sv =====
// Unicycle point-tracking controller: config registers, front end, queue, back end.
// An input beat passes the front-end stages, the queue, the back-end stages, the lanes
// and the output register before tvalid rises. L, the lane count, is the larger of the
// CORDIC stage count (at most 24) and the square-root digit count (15 at defaults).
// Throughput: one tick per cycle unless m_axis_tready stalls; the pipelined lanes set it.
// Reset clears all valid bits and the queue; gains return to 1.0. Disabled ticks vanish.
// Depends on ucpt_pkg, ucpt_front, ucpt_queue, ucpt_back.
module unicycle_point_tracking_control import ucpt_pkg::*; #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// pos_x, pos_y, heading, target_x, target_vx, target_y, target_vy, zero pad
	input  logic [215:0]         s_axis_tdata,
	// enabled
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// speed_cmd, turn_rate_cmd, zero pad
	output logic [39:0]          m_axis_tdata
);

	localparam int UW = ux_width(FRAC_BITS);
	localparam int QW = 2 * UW + HEAD_W;
	localparam logic [GAIN_W-1:0] ONE = GAIN_W'(longint'(1) << FRAC_BITS);

	logic [GAIN_W-1:0]        kx_q, ky_q, hg_q;
	logic                     push, pop;
	logic [QW-1:0]            wentry, rentry;
	queue_stat_t              stat;
	logic [SPEED_W-1:0]       speed;
	logic signed [TURN_W-1:0] turn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_q <= ONE;
			ky_q <= ONE;
			hg_q <= ONE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KX:      kx_q <= cfg_data;
				REG_KY:      ky_q <= cfg_data;
				REG_HEADING: hg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ucpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.kx_gain   (kx_q),
		.ky_gain   (ky_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.enabled   (s_axis_tuser),
		.pos_x     ($signed(s_axis_tdata[31:0])),
		.pos_y     ($signed(s_axis_tdata[63:32])),
		.heading   ($signed(s_axis_tdata[82:64])),
		.target_x  ($signed(s_axis_tdata[114:83])),
		.target_vx ($signed(s_axis_tdata[146:115])),
		.target_y  ($signed(s_axis_tdata[178:147])),
		.target_vy ($signed(s_axis_tdata[210:179])),
		.stat      (stat),
		.push      (push),
		.entry     (wentry)
	);

	ucpt_queue #(.DW(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.pop    (pop),
		.rdata  (rentry),
		.stat   (stat)
	);

	ucpt_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.heading_gain  (hg_q),
		.entry         (rentry),
		.stat          (stat),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.speed_cmd     (speed),
		.turn_rate_cmd (turn)
	);

	assign m_axis_tdata = {7'd0, turn, speed};

endmodule

// ===== tb/ucpt_checker.sv =====
// Checker for the unicycle point-tracking controller: snoops gain writes and both streams,
// predicts speed and turn rate per enabled tick, compares results in order. Needs ucpt_pkg.
module ucpt_checker import ucpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [215:0]         s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [39:0]          m_axis_tdata,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [TURN_W-1:0]  turn;
	} cmd_t;

	localparam longint SPEED_MAX = ((64'sd22 << 16) + 50) / 100;
	localparam longint TURN_MAX  = ((64'sd284 << 16) + 50) / 100;

	logic [GAIN_W-1:0] kx, ky, kh;
	cmd_t cmd_q[$];

	function automatic longint q30_to_frac(input longint a);
		return (a + (64'sd1 << 13)) >>> 14;
	endfunction

	function automatic longint abs_l(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring CORDIC, result in the frac format
	function automatic longint bearing(input longint uy, input longint ux);
		longint x, y, z, base, nx, m;
		int s;
		if (ux == 0 && uy == 0)
			return 0;
		x = ux; y = uy; z = 0; base = 0; s = 0;
		if (ux < 0) begin
			x = -ux;
			y = -uy;
			base = (uy >= 0) ? q30_to_frac(PI_Q30) : -q30_to_frac(PI_Q30);
		end
		m = (x > abs_l(y)) ? x : abs_l(y);
		while (m < (64'sd1 << 40)) begin
			m = m << 1;
			s++;
		end
		x = x <<< s;
		y = y <<< s;
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  += q30_to_frac(ATAN_Q30[i]);
			end else begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  -= q30_to_frac(ATAN_Q30[i]);
			end
			x = nx;
		end
		return base + z;
	endfunction

	function automatic cmd_t control_law(input logic [215:0] d);
		longint px, py, th, tx, tvx, ty, tvy, ux, uy, td, two_pi, e0, ep, em, om;
		longint unsigned spd;
		cmd_t c;
		px  = longint'($signed(d[31:0]));
		py  = longint'($signed(d[63:32]));
		th  = longint'($signed(d[82:64]));
		tx  = longint'($signed(d[114:83]));
		tvx = longint'($signed(d[146:115]));
		ty  = longint'($signed(d[178:147]));
		tvy = longint'($signed(d[210:179]));
		ux = tvx - ((longint'({40'd0, kx}) * (px - tx)) >>> 16);
		uy = tvy - ((longint'({40'd0, ky}) * (py - ty)) >>> 16);
		if (abs_l(ux) > SPEED_MAX || abs_l(uy) > SPEED_MAX)
			spd = SPEED_MAX;
		else begin
			spd = int_sqrt(longint'(ux * ux) + longint'(uy * uy));
			if (spd > SPEED_MAX) spd = SPEED_MAX;
		end
		td = bearing(uy, ux);
		two_pi = 2 * q30_to_frac(PI_Q30);
		e0 = abs_l(th - td);
		ep = abs_l(th - (td + two_pi));
		em = abs_l(th - (td - two_pi));
		if (e0 > ep) td += two_pi;
		else if (e0 > em) td -= two_pi;
		om = (-(longint'({40'd0, kh}) * (th - td))) >>> 16;
		if (om > TURN_MAX) om = TURN_MAX;
		if (om < -TURN_MAX) om = -TURN_MAX;
		c.speed = spd[SPEED_W-1:0];
		c.turn  = om[TURN_W-1:0];
		return c;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t ucpt_checker: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmd_t want, got;
		if (!arst_n) begin
			kx = 24'h010000;
			ky = 24'h010000;
			kh = 24'h010000;
			cmd_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KX:      kx = cfg_data;
					REG_KY:      ky = cfg_data;
					REG_HEADING: kh = cfg_data;
					default:     ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.speed = m_axis_tdata[13:0];
				got.turn  = m_axis_tdata[32:14];
				if (cmd_q.size() == 0)
					report("result with none expected, speed", got.speed, -1);
				else begin
					want = cmd_q.pop_front();
					if (got.speed !== want.speed)
						report("speed_cmd", got.speed, want.speed);
					if (got.turn !== want.turn)
						report("turn_rate_cmd", $signed(got.turn), $signed(want.turn));
					if (m_axis_tdata[39:33] !== '0)
						report("pad bits", m_axis_tdata[39:33], 0);
				end
			end
			// gains written at this edge already apply to a tick taken at the same edge
			if (s_axis_tvalid && s_axis_tready && s_axis_tuser)
				cmd_q.insert(cmd_q.size(), control_law(s_axis_tdata));
			pending = cmd_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the unicycle point-tracking controller testbench: clock, reset, gain phases,
// directed and random ticks, handshake pacing and verdict. Needs ucpt_pkg and ucpt_checker.
module tb_top;
	import ucpt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int  IDLE_LIMIT = 5000;
	localparam int  PI_FIX = 205887;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_data;
	logic                 s_axis_tvalid, s_axis_tready;
	logic [215:0]         s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid, m_axis_tready;
	logic [39:0]          m_axis_tdata;
	int                   errors, pending;
	int                   hold_req;
	int                   burst_left, idle_cycles = 0;

	unicycle_point_tracking_control dut (.*);

	ucpt_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog on any accepted beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// result side: stretches of full rate, coin flip, mostly stalled, or a long hold
	initial begin
		int mode, len;
		bit hold_done;
		m_axis_tready = 0;
		hold_done = 0;
		forever begin
			if (hold_req > 0 && !hold_done) begin
				len = hold_req;
				hold_done = 1;
				m_axis_tready <= 0;
				repeat (len) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(10, 80);
				repeat (len) begin
					case (mode)
						0: m_axis_tready <= 1;
						1: m_axis_tready <= $urandom_range(0, 1);
						default: m_axis_tready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_tick(input logic en, input logic [31:0] px, input logic [31:0] py,
			input logic [18:0] th, input logic [31:0] tx, input logic [31:0] tvx,
			input logic [31:0] ty, input logic [31:0] tvy);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata  <= {5'd0, tvy, ty, tvx, tx, th, py, px};
		s_axis_tuser  <= en;
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// disabled ticks may still be in flight
		repeat (40) @(posedge clk);
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] gx, input logic [GAIN_W-1:0] gy,
			input logic [GAIN_W-1:0] gh);
		cfg_we <= 1;
		cfg_index <= REG_KX;      cfg_data <= gx; @(posedge clk);
		cfg_index <= REG_KY;      cfg_data <= gy; @(posedge clk);
		cfg_index <= REG_HEADING; cfg_data <= gh; @(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [18:0] rand_heading();
		return 19'($signed($urandom_range(0, 2 * PI_FIX)) - PI_FIX);
	endfunction

	function automatic logic [31:0] near(input logic [31:0] v, input int span);
		return v + 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_tick;
		logic [31:0] tx, ty;
		int kind;
		kind = $urandom_range(0, 9);
		tx = $urandom;
		ty = $urandom;
		if (kind < 2)
			send_tick($urandom_range(0, 1), $urandom, $urandom, rand_heading(), tx, $urandom,
				ty, $urandom);
		else if (kind == 2)
			send_tick(0, near(tx, 20000), near(ty, 20000), rand_heading(), tx,
				near(0, 20000), ty, near(0, 20000));
		else if (kind == 3)
			send_tick(1, tx, ty, rand_heading(), tx, near(0, 3), ty, near(0, 3));
		else
			send_tick(1, near(tx, 12000), near(ty, 12000), rand_heading(), tx,
				near(0, 15000), ty, near(0, 15000));
	endtask

	initial begin
		logic [31:0] mx, mn;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_KX;
		cfg_data = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		hold_req = 0;
		burst_left = 0;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed ticks at reset gains
		send_tick(1, mx, mx, 19'(PI_FIX), mn, mx, mn, mx);
		send_tick(1, mn, mn, 19'(-PI_FIX), mx, mn, mx, mn);
		send_tick(1, 0, 0, 0, 0, 0, 0, 0);
		send_tick(1, 100, 200, 19'(PI_FIX), 100, 0, 200, 0);
		send_tick(0, mx, mn, 19'(PI_FIX), mx, mn, mx, mn);
		send_tick(1, 0, 0, 19'(PI_FIX), 0, 32'hFFFF_F000, 0, 0);
		send_tick(1, 0, 0, 19'(-PI_FIX), 0, 32'hFFFF_F000, 0, 0);
		send_tick(1, 0, 0, 19'(-PI_FIX), 0, 32'hFFFF_F000, 0, 32'hFFFF_FFFF);
		send_tick(1, 0, 0, 19'(PI_FIX), 0, 32'hFFFF_F000, 0, 1);
		send_tick(1, 0, 0, 0, 0, 14418, 0, 0);
		send_tick(1, 0, 0, 0, 0, 14419, 0, 0);
		send_tick(1, 0, 0, 0, 0, 0, 0, 32'hFFFF_C7AE);
		send_tick(1, 0, 0, 0, 0, 10000, 0, 10000);
		send_tick(1, 32'h0001_0000, 0, 19'(-PI_FIX), 0, 0, 0, 0);
		send_tick(1, 0, 32'hFFFF_0000, 19'(PI_FIX), 0, 0, 0, 0);
		send_tick(1, 5000, 5000, 19'h3FFFF, 0, 0, 0, 0);
		drain();

		// write enable stays high into the first gain phase
		cfg_we <= 1;
		cfg_index <= REG_SPARE;
		cfg_data <= '1;
		@(posedge clk);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_gains(24'h010000, 24'h010000, 24'h010000);
				1: set_gains(24'h000000, 24'h000000, 24'h000000);
				2: set_gains(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
				3: set_gains($urandom_range(0, 24'h04_0000), $urandom_range(0, 24'h04_0000),
					$urandom_range(0, 24'hFF_FFFF));
				default: set_gains(24'h008000, 24'h018000, 24'h000100);
			endcase
			for (int n = 0; n < 230; n++) begin
				if (phase == 1 && n == 20)
					hold_req = 400;
				if (phase == 3 && n == 100)
					drain();
				random_tick();
			end
			drain();
		end

		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== unicycle_point_tracking_control.f =====
hdl/ucpt_pkg.sv
hdl/ucpt_front.sv
hdl/ucpt_queue.sv
hdl/ucpt_back.sv
hdl/unicycle_point_tracking_control.sv
tb/ucpt_checker.sv
tb/tb_top.sv
